@@ src/hwqb_pkg.sv @@
// hwqb_pkg: types, constants and helpers of the height weighted quad blend unit
// used by hwqb_corner, hwqb_lane_div and height_weighted_quad_blend_unit
// no dependencies
package hwqb_pkg;

  // largest image edge taken from the size registers
  localparam logic [12:0] MaxSize = 13'd4096;

  // square root: 21 root bits, three per stage
  localparam int SqStages       = 7;
  localparam int SqBitsPerStage = 3;
  localparam int RootW          = 21;
  localparam int RadW           = 42;
  localparam int RemW           = RootW + 3;

  // distance scale quotient: 15 bits, three per stage
  localparam int DivStages       = 5;
  localparam int DivBitsPerStage = 3;
  localparam int QW              = 15;

  // lane divider: 8 quotient bits, two per stage
  localparam int LaneDivStages    = 4;
  localparam int LaneBitsPerStage = 2;
  localparam int NumW             = 33;
  localparam int DenW             = 25;

  // register count of one corner weight lane and of the whole path
  localparam int CornerLat = 3 + SqStages + 1 + DivStages + 1;
  localparam int TotalLat  = 1 + CornerLat + 5 + LaneDivStages + 1;

  // register indexes
  localparam logic [2:0] RegImageWidth    = 3'd0;
  localparam logic [2:0] RegImageHeight   = 3'd1;
  localparam logic [2:0] RegBlendFactor   = 3'd2;
  localparam logic [2:0] RegInfluenceRow0 = 3'd3;
  localparam logic [2:0] RegInfluenceRow1 = 3'd4;
  localparam logic [2:0] RegInfluenceRow2 = 3'd5;

  // input word
  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] color_a;
    logic [31:0] color_b;
    logic [31:0] color_c;
    logic [31:0] color_d;
    logic [7:0]  height_a;
    logic [7:0]  height_b;
    logic [7:0]  height_c;
    logic [7:0]  height_d;
  } pix_word_t;

  // result word
  typedef struct packed {
    logic [31:0] blended_color;
    logic [2:0]  corner_base;
  } blend_word_t;

  // operands of one corner weight lane
  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic [12:0] cx;
    logic [12:0] cy;
    logic [15:0] infl;
    logic [11:0] scale;
  } corner_in_t;

  // colors, heights and quadrant that ride along the weight lanes
  typedef struct packed {
    logic [3:0][31:0] col;
    logic [3:0][7:0]  hgt;
    logic [2:0]       base;
  } side_t;

  // influence of one grid cell from the three packed rows
  function automatic logic [15:0] infl_of(input logic [47:0] r0, input logic [47:0] r1,
                                          input logic [47:0] r2, input logic [3:0] grid_idx);
    logic [15:0] v;
    case (grid_idx)
      4'd0: v = r0[15:0];
      4'd1: v = r0[31:16];
      4'd2: v = r0[47:32];
      4'd3: v = r1[15:0];
      4'd4: v = r1[31:16];
      4'd5: v = r1[47:32];
      4'd6: v = r2[15:0];
      4'd7: v = r2[31:16];
      4'd8: v = r2[47:32];
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/hwqb_corner.sv @@
// hwqb_corner: pipelined Q1.15 weight of one corner (distance, square root, scale, clamp)
// depends on hwqb_pkg
module hwqb_corner import hwqb_pkg::*; (
  input  logic       clk_i,
  input  corner_in_t corner_i,
  output logic [15:0] weight_o
);

  localparam int InflDly = 3 + SqStages;

  logic [12:0] adx_q, ady_q;
  logic [25:0] sqx_q, sqy_q, d2_q;
  logic [15:0] infl_q [InflDly];
  logic [11:0] scale_q [InflDly+1];
  logic [RadW-1:0]  rad_d [SqStages];
  logic [RadW-1:0]  rad_q [SqStages];
  logic [RemW-1:0]  srem_d [SqStages];
  logic [RemW-1:0]  srem_q [SqStages];
  logic [RootW-1:0] root_d [SqStages];
  logic [RootW-1:0] root_q [SqStages];
  logic [36:0] prod_q;
  logic [26:0] drem_d [DivStages];
  logic [26:0] drem_q [DivStages];
  logic [QW-1:0] dq_d [DivStages];
  logic [QW-1:0] dq_q [DivStages];
  logic [11:0] dscl_d [DivStages];
  logic [11:0] dscl_q [DivStages];
  logic        dsat_d [DivStages];
  logic        dsat_q [DivStages];
  logic [15:0] w_q;
  logic signed [13:0] dx, dy;

  // absolute distances to the corner
  assign dx = $signed({2'b00, corner_i.px}) - $signed({1'b0, corner_i.cx});
  assign dy = $signed({2'b00, corner_i.py}) - $signed({1'b0, corner_i.cy});

  always_ff @(posedge clk_i) begin
    adx_q <= dx[13] ? 13'(-dx) : dx[12:0];
    ady_q <= dy[13] ? 13'(-dy) : dy[12:0];
    sqx_q <= adx_q * adx_q;
    sqy_q <= ady_q * ady_q;
    d2_q  <= sqx_q + sqy_q;
  end

  // influence and scale ride along
  always_ff @(posedge clk_i) begin
    infl_q[0]  <= corner_i.infl;
    scale_q[0] <= corner_i.scale;
    for (int k = 1; k < InflDly; k++) infl_q[k] <= infl_q[k-1];
    for (int k = 1; k <= InflDly; k++) scale_q[k] <= scale_q[k-1];
  end

  // square root, three result bits per stage
  always_comb begin
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RemW-1:0]  trial;
    logic [RootW-1:0] root;
    for (int k = 0; k < SqStages; k++) begin
      if (k == 0) begin
        rad  = {d2_q, 16'd0};
        rem  = '0;
        root = '0;
      end else begin
        rad  = rad_q[k-1];
        rem  = srem_q[k-1];
        root = root_q[k-1];
      end
      for (int s = 0; s < SqBitsPerStage; s++) begin
        rem   = {rem[RemW-3:0], rad[RadW-1 -: 2]};
        rad   = {rad[RadW-3:0], 2'b00};
        trial = {1'b0, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[RootW-2:0], 1'b1};
        end else begin
          root = {root[RootW-2:0], 1'b0};
        end
      end
      rad_d[k]  = rad;
      srem_d[k] = rem;
      root_d[k] = root;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SqStages; k++) begin
      rad_q[k]  <= rad_d[k];
      srem_q[k] <= srem_d[k];
      root_q[k] <= root_d[k];
    end
  end

  // distance times influence
  always_ff @(posedge clk_i) begin
    prod_q <= root_q[SqStages-1] * infl_q[InflDly-1];
  end

  // quotient by twice the half width, saturating at one
  always_comb begin
    logic [26:0]   rem;
    logic [QW-1:0] q;
    logic [11:0]   scl;
    logic          sat;
    int            j;
    for (int k = 0; k < DivStages; k++) begin
      if (k == 0) begin
        scl = scale_q[InflDly];
        sat = prod_q >= {9'd0, scl, 16'd0};
        rem = prod_q[27:1];
        q   = '0;
      end else begin
        scl = dscl_q[k-1];
        sat = dsat_q[k-1];
        rem = drem_q[k-1];
        q   = dq_q[k-1];
      end
      for (int s = 0; s < DivBitsPerStage; s++) begin
        j = QW - 1 - (k * DivBitsPerStage + s);
        if (rem >= ({15'd0, scl} << j)) begin
          rem = rem - ({15'd0, scl} << j);
          q   = {q[QW-2:0], 1'b1};
        end else begin
          q   = {q[QW-2:0], 1'b0};
        end
      end
      drem_d[k] = rem;
      dq_d[k]   = q;
      dscl_d[k] = scl;
      dsat_d[k] = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivStages; k++) begin
      drem_q[k] <= drem_d[k];
      dq_q[k]   <= dq_d[k];
      dscl_q[k] <= dscl_d[k];
      dsat_q[k] <= dsat_d[k];
    end
  end

  // weight is one minus the scaled distance
  always_ff @(posedge clk_i) begin
    w_q <= dsat_q[DivStages-1] ? 16'd0 : 16'd32768 - {1'b0, dq_q[DivStages-1]};
  end

  assign weight_o = w_q;

endmodule

@@ src/hwqb_lane_div.sv @@
// hwqb_lane_div: pipelined 8-bit quotient of one byte lane's weighted sum by the level sum
// depends on hwqb_pkg
module hwqb_lane_div import hwqb_pkg::*; (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [7:0]      quot_o
);

  logic [NumW-1:0] rem_d [LaneDivStages];
  logic [NumW-1:0] rem_q [LaneDivStages];
  logic [DenW-1:0] den_d [LaneDivStages];
  logic [DenW-1:0] den_q [LaneDivStages];
  logic [7:0]      q_d   [LaneDivStages];
  logic [7:0]      q_q   [LaneDivStages];

  // restoring division, two quotient bits per stage
  always_comb begin
    logic [NumW-1:0] rem;
    logic [DenW-1:0] den;
    logic [7:0]      q;
    int              j;
    for (int k = 0; k < LaneDivStages; k++) begin
      if (k == 0) begin
        rem = num_i;
        den = den_i;
        q   = '0;
      end else begin
        rem = rem_q[k-1];
        den = den_q[k-1];
        q   = q_q[k-1];
      end
      for (int s = 0; s < LaneBitsPerStage; s++) begin
        j = 7 - (k * LaneBitsPerStage + s);
        if (rem >= ({8'd0, den} << j)) begin
          rem = rem - ({8'd0, den} << j);
          q   = {q[6:0], 1'b1};
        end else begin
          q   = {q[6:0], 1'b0};
        end
      end
      rem_d[k] = rem;
      den_d[k] = den;
      q_d[k]   = q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LaneDivStages; k++) begin
      rem_q[k] <= rem_d[k];
      den_q[k] <= den_d[k];
      q_q[k]   <= q_d[k];
    end
  end

  assign quot_o = q_q[LaneDivStages-1];

endmodule

@@ src/height_weighted_quad_blend_unit.sv @@
// height_weighted_quad_blend_unit: top level, register port, quadrant select and blend
// depends on hwqb_pkg, hwqb_corner, hwqb_lane_div
//
// Takes one pixel word per clock whenever start is high; busy never rises. Each word's
// blended RGBA result appears on blend_o with done_o high for one cycle, in input
// order. The receiver cannot stall the block. The latency is set by the four corner
// lanes (seven stages of a 21-bit square root, five stages of a 15-bit quotient) and
// by the four 8-bit lane dividers of four stages each.
module height_weighted_quad_blend_unit import hwqb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  pix_word_t   pix_i,
  output logic        done_o,
  output blend_word_t blend_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [12:0] width_q, height_q;
  logic [15:0] bf_q;
  logic [47:0] row_q [3];
  logic [2:0]  cfg_idx;
  logic        accept;
  logic [TotalLat-1:0] vld_q;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign accept  = start && !busy;
  assign cfg_idx = paddr[5:3];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd256;
      height_q <= 13'd256;
      bf_q     <= 16'd4096;
      row_q[0] <= 48'h0100_0100_0100;
      row_q[1] <= 48'h0100_0100_0100;
      row_q[2] <= 48'h0100_0100_0100;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        RegImageWidth:    width_q  <= pwdata[12:0];
        RegImageHeight:   height_q <= pwdata[12:0];
        RegBlendFactor:   bf_q     <= pwdata[15:0];
        RegInfluenceRow0: row_q[0] <= pwdata[47:0];
        RegInfluenceRow1: row_q[1] <= pwdata[47:0];
        RegInfluenceRow2: row_q[2] <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      RegImageWidth:    prdata = {51'd0, width_q};
      RegImageHeight:   prdata = {51'd0, height_q};
      RegBlendFactor:   prdata = {48'd0, bf_q};
      RegInfluenceRow0: prdata = {16'd0, row_q[0]};
      RegInfluenceRow1: prdata = {16'd0, row_q[1]};
      RegInfluenceRow2: prdata = {16'd0, row_q[2]};
      default:          prdata = '0;
    endcase
  end

  // valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TotalLat-2:0], accept};
    end
  end

  // quadrant, corner positions and influences
  logic [12:0] w_eff, h_eff, cx1, cy2;
  logic [11:0] hw, hh, scale, lx, ly;
  logic        right, up;
  logic [2:0]  base;
  logic [3:0]  grid_idx [4];
  corner_in_t  cin_d [4];
  corner_in_t  cin_q [4];
  side_t       side_d;
  side_t       side_q [CornerLat+1];

  always_comb begin
    w_eff   = (width_q > MaxSize) ? MaxSize : width_q;
    h_eff   = (height_q > MaxSize) ? MaxSize : height_q;
    hw      = w_eff[12:1];
    hh      = h_eff[12:1];
    scale   = (hw == 12'd0) ? 12'd1 : hw;
    right   = pix_i.pixel_x >= hw;
    up      = pix_i.pixel_y >= hh;
    base    = (right ? 3'd1 : 3'd0) + (up ? 3'd3 : 3'd0);
    lx      = right ? hw : 12'd0;
    ly      = up ? hh : 12'd0;
    cx1     = {1'b0, lx} + {1'b0, hw};
    cy2     = {1'b0, ly} + {1'b0, hh};
    grid_idx[0] = {1'b0, base};
    grid_idx[1] = {1'b0, base} + 4'd1;
    grid_idx[2] = {1'b0, base} + 4'd3;
    grid_idx[3] = {1'b0, base} + 4'd4;
    for (int i = 0; i < 4; i++) begin
      cin_d[i].px    = pix_i.pixel_x;
      cin_d[i].py    = pix_i.pixel_y;
      cin_d[i].cx    = (i == 1 || i == 3) ? cx1 : {1'b0, lx};
      cin_d[i].cy    = (i >= 2) ? cy2 : {1'b0, ly};
      cin_d[i].infl  = infl_of(row_q[0], row_q[1], row_q[2], grid_idx[i]);
      cin_d[i].scale = scale;
    end
    side_d.col  = {pix_i.color_d, pix_i.color_c, pix_i.color_b, pix_i.color_a};
    side_d.hgt  = {pix_i.height_d, pix_i.height_c, pix_i.height_b, pix_i.height_a};
    side_d.base = base;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) cin_q[i] <= cin_d[i];
    side_q[0] <= side_d;
    for (int k = 1; k <= CornerLat; k++) side_q[k] <= side_q[k-1];
  end

  // corner weight lanes
  logic [15:0] wgt [4];

  for (genvar g = 0; g < 4; g++) begin : g_corner
    hwqb_corner u_corner (
      .clk_i    (clk_i),
      .corner_i (cin_q[g]),
      .weight_o (wgt[g])
    );
  end

  // weighted heights
  logic [23:0]      wt_q [4];
  logic [3:0][31:0] ta_col_q;
  logic [2:0]       ta_base_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) wt_q[i] <= side_q[CornerLat].hgt[i] * wgt[i];
    ta_col_q  <= side_q[CornerLat].col;
    ta_base_q <= side_q[CornerLat].base;
  end

  // largest weighted height, first corner wins a tie
  logic [23:0]      maxh;
  logic [1:0]       best;
  logic [23:0]      tb_wt_q [4];
  logic [23:0]      tb_max_q;
  logic [1:0]       tb_best_q;
  logic [3:0][31:0] tb_col_q;
  logic [2:0]       tb_base_q;

  always_comb begin
    maxh = '0;
    best = '0;
    for (int i = 0; i < 4; i++) begin
      if (wt_q[i] > maxh) begin
        maxh = wt_q[i];
        best = 2'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) tb_wt_q[i] <= wt_q[i];
    tb_max_q  <= maxh;
    tb_best_q <= best;
    tb_col_q  <= ta_col_q;
    tb_base_q <= ta_base_q;
  end

  // levels above the blend band
  logic [23:0]      top [4];
  logic [22:0]      lev_q [4];
  logic [1:0]       tc_best_q;
  logic [3:0][31:0] tc_col_q;
  logic [2:0]       tc_base_q;

  always_comb begin
    for (int i = 0; i < 4; i++) top[i] = tb_wt_q[i] + {1'b0, bf_q, 7'd0};
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      lev_q[i] <= (top[i] > tb_max_q) ? 23'(top[i] - tb_max_q) : 23'd0;
    end
    tc_best_q <= tb_best_q;
    tc_col_q  <= tb_col_q;
    tc_base_q <= tb_base_q;
  end

  // per lane products and level sum
  logic [30:0]     prod_q [4][4];
  logic [DenW-1:0] sum_q;
  logic [31:0]     td_fb_q;
  logic [2:0]      td_base_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < 4; i++) prod_q[l][i] <= tc_col_q[i][8*l +: 8] * lev_q[i];
    end
    sum_q     <= {2'b00, lev_q[0]} + {2'b00, lev_q[1]} + {2'b00, lev_q[2]} +
                 {2'b00, lev_q[3]};
    td_fb_q   <= tc_col_q[tc_best_q];
    td_base_q <= tc_base_q;
  end

  // lane numerators with half the sum for rounding
  logic [NumW-1:0] num_q [4];
  logic [DenW-1:0] den_q;
  typedef struct packed {
    logic        zero;
    logic [31:0] fb;
    logic [2:0]  base;
  } tail_t;
  tail_t te_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      num_q[l] <= {2'b00, prod_q[l][0]} + {2'b00, prod_q[l][1]} + {2'b00, prod_q[l][2]} +
                  {2'b00, prod_q[l][3]} + {9'd0, sum_q[DenW-1:1]};
    end
    den_q     <= sum_q;
    te_q.zero <= sum_q == '0;
    te_q.fb   <= td_fb_q;
    te_q.base <= td_base_q;
  end

  // lane dividers
  logic [7:0] quot [4];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    hwqb_lane_div u_div (
      .clk_i  (clk_i),
      .num_i  (num_q[g]),
      .den_i  (den_q),
      .quot_o (quot[g])
    );
  end

  tail_t tail_q [LaneDivStages];

  always_ff @(posedge clk_i) begin
    tail_q[0] <= te_q;
    for (int k = 1; k < LaneDivStages; k++) tail_q[k] <= tail_q[k-1];
  end

  // output word
  blend_word_t out_q;

  always_ff @(posedge clk_i) begin
    out_q.blended_color <= tail_q[LaneDivStages-1].zero ? tail_q[LaneDivStages-1].fb :
                           {quot[3], quot[2], quot[1], quot[0]};
    out_q.corner_base   <= tail_q[LaneDivStages-1].base;
  end

  assign blend_o = out_q;
  assign done_o  = vld_q[TotalLat-1];

`ifndef NO_ASSERTIONS
  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##TotalLat done_o) else $error("result word missing");

  // no result word without an accepted word
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, TotalLat)) else $error("result word invented");

  // the lower-left grid cell is always a valid quadrant corner
  a_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (blend_o.corner_base == 3'd0 || blend_o.corner_base == 3'd1 ||
                blend_o.corner_base == 3'd3 || blend_o.corner_base == 3'd4))
    else $error("bad corner base");
`endif

endmodule

@@ verif/height_weighted_quad_blend_unit_tb.sv @@
// height_weighted_quad_blend_unit_tb: self-checking testbench of the quad blend unit
// drives pixel words and register writes, predicts each blended word, checks every done strobe
// depends on hwqb_pkg and height_weighted_quad_blend_unit
module height_weighted_quad_blend_unit_tb;
  import hwqb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  pix_word_t   pix_i;
  logic        done_o;
  blend_word_t blend_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  height_weighted_quad_blend_unit DUT (.*);

  // shadow copy of the register file
  logic [12:0] shd_width;
  logic [12:0] shd_height;
  logic [15:0] shd_blend;
  logic [47:0] shd_infl [3];

  blend_word_t pending_blends [$];
  int unsigned mismatch_cnt;
  int unsigned quiet_left;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // global time limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // q1.15 weight of one corner
  function automatic longint unsigned corner_wt(input longint px, input longint py,
                                                input longint cx, input longint cy,
                                                input longint unsigned infl,
                                                input longint unsigned scale);
    longint dx;
    longint dy;
    longint unsigned len;
    longint unsigned t;
    dx = px - cx;
    dy = py - cy;
    len = int_sqrt((longint'(dx * dx) + longint'(dy * dy)) << 16);
    t = (len * infl) / (2 * scale);
    if (t > 32768) t = 32768;
    return 32768 - t;
  endfunction

  // expected blended word for one pixel under the shadow registers
  function automatic blend_word_t predict_blend(input pix_word_t p);
    longint unsigned w, h, hw, hh, scale, lx, ly, base, maxh, bf, sum, num, v, top;
    longint unsigned col [4];
    longint unsigned hgt [4];
    longint unsigned wt [4];
    longint unsigned lev [4];
    longint unsigned grid_idx [4];
    longint cx [4];
    longint cy [4];
    logic [31:0] res;
    int best;
    blend_word_t r;
    w = (shd_width > MaxSize) ? MaxSize : shd_width;
    h = (shd_height > MaxSize) ? MaxSize : shd_height;
    hw = w >> 1;
    hh = h >> 1;
    scale = (hw == 0) ? 1 : hw;
    col[0] = p.color_a; col[1] = p.color_b; col[2] = p.color_c; col[3] = p.color_d;
    hgt[0] = p.height_a; hgt[1] = p.height_b; hgt[2] = p.height_c; hgt[3] = p.height_d;
    base = 0; lx = 0; ly = 0;
    if (p.pixel_x >= hw) begin
      base += 1;
      lx = hw;
    end
    if (p.pixel_y >= hh) begin
      base += 3;
      ly = hh;
    end
    grid_idx[0] = base; grid_idx[1] = base + 1; grid_idx[2] = base + 3; grid_idx[3] = base + 4;
    cx[0] = lx;      cy[0] = ly;
    cx[1] = lx + hw; cy[1] = ly;
    cx[2] = lx;      cy[2] = ly + hh;
    cx[3] = lx + hw; cy[3] = ly + hh;
    maxh = 0;
    best = 0;
    for (int i = 0; i < 4; i++) begin
      wt[i] = hgt[i] * corner_wt(p.pixel_x, p.pixel_y, cx[i], cy[i],
                                 (shd_infl[grid_idx[i] / 3] >> (16 * (grid_idx[i] % 3)))
                                 & 16'hFFFF, scale);
      if (wt[i] > maxh) begin
        maxh = wt[i];
        best = i;
      end
    end
    bf = longint'(shd_blend) << 7;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      top = wt[i] + bf;
      lev[i] = (top > maxh) ? top - maxh : 0;
      sum += lev[i];
    end
    // zero level sum falls back to the tallest corner
    if (sum == 0) begin
      res = 32'(col[best]);
    end else begin
      for (int lane = 0; lane < 4; lane++) begin
        num = 0;
        for (int i = 0; i < 4; i++) num += ((col[i] >> (8 * lane)) & 8'hFF) * lev[i];
        v = (num + sum / 2) / sum;
        if (v > 255) v = 255;
        res[8*lane +: 8] = 8'(v);
      end
    end
    r.blended_color = res;
    r.corner_base = 3'(base);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    blend_word_t want;
    if (rst_ni && done_o) begin
      if (pending_blends.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected word: %h", blend_o);
      end else begin
        want = pending_blends.pop_front();
        if (blend_o.blended_color !== want.blended_color ||
            blend_o.corner_base !== want.corner_base) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: color exp %h got %h, base exp %0d got %0d",
                     want.blended_color, blend_o.blended_color,
                     want.corner_base, blend_o.corner_base);
        end
      end
    end
  end

  // send one pixel word; start stays high on return unless an occasional random pause drops it
  task automatic send_pixel(input pix_word_t p);
    start <= 1'b1;
    pix_i <= p;
    do @(posedge clk_i); while (busy);
    pending_blends.push_back(predict_blend(p));
    if (quiet_left > 0) begin
      quiet_left--;
    end else if ($urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // hold off until every expected word has come
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_blends.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, setup and access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegImageWidth:    shd_width = val[12:0];
      RegImageHeight:   shd_height = val[12:0];
      RegBlendFactor:   shd_blend = val[15:0];
      RegInfluenceRow0: shd_infl[0] = val[47:0];
      RegInfluenceRow1: shd_infl[1] = val[47:0];
      RegInfluenceRow2: shd_infl[2] = val[47:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [12:0] w, input logic [12:0] h, input logic [15:0] bf,
                          input logic [47:0] i0, input logic [47:0] i1, input logic [47:0] i2);
    drain();
    reg_write(RegImageWidth, {51'd0, w});
    reg_write(RegImageHeight, {51'd0, h});
    reg_write(RegBlendFactor, {48'd0, bf});
    reg_write(RegInfluenceRow0, {16'd0, i0});
    reg_write(RegInfluenceRow1, {16'd0, i1});
    reg_write(RegInfluenceRow2, {16'd0, i2});
  endtask

  function automatic pix_word_t rand_pixel(input bit in_image);
    pix_word_t p;
    logic [191:0] rbits;
    rbits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = rbits[$bits(pix_word_t)-1:0];
    if (in_image && shd_width > 0 && shd_height > 0) begin
      p.pixel_x = 12'($urandom_range(((shd_width > MaxSize) ? MaxSize : shd_width) - 1));
      p.pixel_y = 12'($urandom_range(((shd_height > MaxSize) ? MaxSize : shd_height) - 1));
    end
    // zero and tied heights now and then
    case ($urandom_range(7))
      0: {p.height_a, p.height_b, p.height_c, p.height_d} = '0;
      1: {p.height_b, p.height_c, p.height_d} = {3{p.height_a}};
      2: p.height_b = 8'hFF;
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [47:0] rand_infl();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {3{16'h0100}};
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [12:0] rand_size();
    case ($urandom_range(7))
      0: return 13'($urandom_range(1));
      1: return MaxSize;
      2: return 13'($urandom_range(8191, 4097));
      3: return 13'($urandom_range(2, 64));
      default: return 13'($urandom_range(2, 4096));
    endcase
  endfunction

  // directed: reset values, extreme positions, ties, zero level sum
  task automatic test_directed;
    pix_word_t p;
    p = '0;
    p.color_a = 32'hFF00_00FF; p.color_b = 32'h00FF_00FF;
    p.color_c = 32'h0000_FFFF; p.color_d = 32'hFFFF_FFFF;
    p.height_a = 8'hFF; p.height_b = 8'hFF; p.height_c = 8'hFF; p.height_d = 8'hFF;
    send_pixel(p);
    p.pixel_x = 12'hFFF; p.pixel_y = 12'hFFF; send_pixel(p);
    p.pixel_x = 127; p.pixel_y = 128; send_pixel(p);
    p.pixel_x = 128; p.pixel_y = 127; send_pixel(p);
    p.height_a = 0; p.height_b = 0; p.height_c = 0; p.height_d = 0; send_pixel(p);
    // zero blend band: only the tallest corner, ties go to the first
    set_regs(256, 256, 16'h0000, {3{16'h0100}}, {3{16'h0100}}, {3{16'h0100}});
    p.pixel_x = 64; p.pixel_y = 64; p.height_a = 8'h80; p.height_b = 8'h80;
    send_pixel(p);
    p.height_a = 0; p.height_b = 0; p.height_c = 0; p.height_d = 0; send_pixel(p);
    p.height_d = 8'hFF; send_pixel(p);
    // widest band, strongest influences
    set_regs(8191, 8191, 16'hFFFF, '1, '1, '1);
    p.pixel_x = 0; p.pixel_y = 0; send_pixel(p);
    p.pixel_x = 12'hFFF; p.pixel_y = 12'h800; send_pixel(p);
    p.color_a = '1; p.color_b = '1; p.color_c = '1; p.color_d = '1; send_pixel(p);
    // zero half size and zero influences
    set_regs(1, 0, 16'h0001, '0, '0, '0);
    p.pixel_x = 0; p.pixel_y = 0; send_pixel(p);
    p.pixel_x = 5; p.pixel_y = 12'hFFF; send_pixel(p);
    set_regs(2, 2, 16'h1000, {16'h0100, 16'h0200, 16'h0300},
             {16'h0400, 16'h0500, 16'h0600}, {16'h0700, 16'h0800, 16'h0900});
    for (int i = 0; i < 8; i++) send_pixel(rand_pixel(i[0]));
  endtask

  // random: several register settings, mostly in-image pixels
  task automatic test_random;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) set_regs(MaxSize, MaxSize, 16'hFFFF, '1, '1, '1);
      else set_regs(rand_size(), rand_size(), 16'($urandom), rand_infl(), rand_infl(),
                    rand_infl());
      quiet_left = (ph == 2) ? 150 : 0;
      for (int n = 0; n < 225; n++) begin
        if (ph == 3 && n == 100) drain();
        send_pixel(rand_pixel($urandom_range(4) != 0));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    pix_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_cnt = 0;
    quiet_left = 0;
    shd_width = 256;
    shd_height = 256;
    shd_blend = 4096;
    for (int i = 0; i < 3; i++) shd_infl[i] = 48'd1099528405248;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain();
    repeat (TotalLat + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_blends.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ height_weighted_quad_blend_unit.f @@
src/hwqb_pkg.sv
src/hwqb_corner.sv
src/hwqb_lane_div.sv
src/height_weighted_quad_blend_unit.sv
verif/height_weighted_quad_blend_unit_tb.sv
